[rtl/core/gpad_pkg.sv]
// Shared types and constants of the gamepad button auto-repeat block.
// Used by every module under rtl/core; depends on nothing.
package gpad_pkg;

  // Number of buttons the block serves, and how many of them fit the 32-bit bitmaps.
  localparam int BUTTONS = 32;
  localparam int MAP_W   = 32;
  localparam int LANES   = (BUTTONS < MAP_W) ? BUTTONS : MAP_W;

  // Hold counter and configuration register width.
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] HOLD_MAX = '1;

  // One remainder step per hold counter bit.
  localparam int STEPS  = CNT_W;
  localparam int STEP_W = $clog2(STEPS);

  // Buttons at or above LANES never show up in any bitmap.
  localparam logic [MAP_W-1:0] ACTIVE_MASK =
      (LANES >= MAP_W) ? {MAP_W{1'b1}} : MAP_W'((64'd1 << LANES) - 64'd1);

  // Configuration port.
  localparam int CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOLD_FRAMES   = 8'd0,
    CFG_REPEAT_PERIOD = 8'd1
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MERGE
  } seq_state_e;

  // Controls from the sequencer to the lanes and the merge stage.
  typedef struct packed {
    logic load;   // a frame beat is accepted this cycle
    logic step;   // one remainder step in every lane
    logic merge;  // combine the lane results into the output register
  } gpad_ctl_t;

  // Status from the merge stage back to the sequencer.
  typedef struct packed {
    logic out_free;  // the output register can take a result this cycle
  } gpad_sts_t;

endpackage

[rtl/core/gpad_lane.sv]
// One button lane: hold counter and a bit-serial remainder unit.
// Depends on gpad_pkg for widths and the control struct.
module gpad_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gpad_pkg::gpad_ctl_t        ctl_i,
  input  logic                       cur_i,
  input  logic                       last_i,
  input  logic [gpad_pkg::CNT_W-1:0] hold_frames_i,
  input  logic [gpad_pkg::CNT_W-1:0] repeat_period_i,
  output logic                       hit_o
);

  logic [gpad_pkg::CNT_W-1:0] hold_q, hold_d;
  logic [gpad_pkg::CNT_W-1:0] div_q, div_d;
  logic [gpad_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [gpad_pkg::CNT_W:0]   trial;

  // Hold counter: counts while the button stays down, saturating at the top.
  always_comb begin
    hold_d = hold_q;
    if (ctl_i.load) begin
      if (last_i && cur_i) begin
        if (hold_q != gpad_pkg::HOLD_MAX) begin
          hold_d = hold_q + gpad_pkg::CNT_W'(1);
        end
      end else begin
        hold_d = '0;
      end
    end
  end

  // Restoring remainder of the new count by the period, one bit per step.
  assign trial = {rem_q, div_q[gpad_pkg::CNT_W-1]};

  always_comb begin
    div_d = div_q;
    rem_d = rem_q;
    if (ctl_i.load) begin
      div_d = hold_d;
      rem_d = '0;
    end else if (ctl_i.step) begin
      div_d = {div_q[gpad_pkg::CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, repeat_period_i}) begin
        rem_d = gpad_pkg::CNT_W'(trial - {1'b0, repeat_period_i});
      end else begin
        rem_d = trial[gpad_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
  end

  // Past the threshold and on a repeat frame, the button counts as freshly pressed.
  assign hit_o = (hold_q >= hold_frames_i) &&
                 ((repeat_period_i == '0) || (rem_q == '0));

endmodule

[rtl/core/gpad_seq.sv]
// Frame sequencer: accept, remainder steps in all lanes, then merge.
// Depends on gpad_pkg for the state enum and the control structs.
module gpad_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gpad_pkg::gpad_sts_t sts_i,
  output gpad_pkg::gpad_ctl_t ctl_o
);

  gpad_pkg::seq_state_e        state_q, state_d;
  logic [gpad_pkg::STEP_W-1:0] step_q, step_d;
  logic                        last_step;

  assign last_step = (step_q == gpad_pkg::STEP_W'(gpad_pkg::STEPS - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      gpad_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = gpad_pkg::ST_DIV;
        end
      end
      gpad_pkg::ST_DIV: begin
        step_d = step_q + gpad_pkg::STEP_W'(1);
        if (last_step) begin
          state_d = gpad_pkg::ST_MERGE;
        end
      end
      gpad_pkg::ST_MERGE: begin
        if (sts_i.out_free) begin
          state_d = gpad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gpad_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    ctl_o.load  = 1'b0;
    ctl_o.step  = 1'b0;
    ctl_o.merge = 1'b0;
    unique case (state_q)
      gpad_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      gpad_pkg::ST_DIV: begin
        ctl_o.step = 1'b1;
      end
      gpad_pkg::ST_MERGE: begin
        ctl_o.merge = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpad_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[rtl/core/gpad_merge.sv]
// Merge stage: previous-frame levels, lane results and the output register.
// Depends on gpad_pkg for widths and the control/status structs.
module gpad_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gpad_pkg::gpad_ctl_t        ctl_i,
  input  logic [gpad_pkg::MAP_W-1:0] cur_i,
  input  logic [gpad_pkg::MAP_W-1:0] hit_i,
  output logic [gpad_pkg::MAP_W-1:0] last_o,
  output gpad_pkg::gpad_sts_t        sts_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gpad_pkg::MAP_W-1:0] levels_o,
  output logic [gpad_pkg::MAP_W-1:0] new_press_o,
  output logic [gpad_pkg::MAP_W-1:0] repeat_press_o
);

  logic [gpad_pkg::MAP_W-1:0] cur_q;
  logic [gpad_pkg::MAP_W-1:0] last_q, last_d;
  logic                       valid_q, valid_d;
  logic [gpad_pkg::MAP_W-1:0] levels_q, new_q, rep_q;

  assign sts_o.out_free = !valid_q || out_ready_i;

  // Output valid holds until the beat is taken.
  always_comb begin
    last_d  = last_q;
    valid_d = valid_q;
    if (ctl_i.merge) begin
      last_d  = cur_q;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  // Frame capture and result bitmaps; a lane hit hides the previous level.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cur_q <= cur_i & gpad_pkg::ACTIVE_MASK;
    end
    if (ctl_i.merge) begin
      levels_q <= cur_q;
      new_q    <= cur_q & ~last_q;
      rep_q    <= cur_q & (~last_q | hit_i);
    end
  end

  assign last_o         = last_q;
  assign out_valid_o    = valid_q;
  assign levels_o       = levels_q;
  assign new_press_o    = new_q;
  assign repeat_press_o = rep_q;

endmodule

[rtl/core/gamepad_button_autorepeat.sv]
// Top level of the gamepad button auto-repeat block: config registers, lanes,
// sequencer and merge stage. Depends on gpad_pkg and the gpad_* modules.
//
// Each input beat is one frame's button bitmap; each frame gives one output beat
// with the current levels, the new presses and the presses with auto-repeat.
// Per frame, in order: the beat is taken and the hold counters updated, 16
// remainder steps (one per counter bit, all button lanes in parallel) test the
// hold count against the repeat period, and the lanes are merged into the output
// register once it is free. The next frame is accepted while the previous result
// still waits to be taken. The user must write hold_frames (index 0) and
// repeat_period (index 1) through the config channel only while no frame is in
// flight; the block does not enforce this. Writes to other indexes are dropped.
module gamepad_button_autorepeat (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Frame input, tdata: buttons[31:0].
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [31:0]                    s_axis_tdata_i,
  // Result output, tdata: levels[31:0], new_press[63:32], repeat_press[95:64].
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [95:0]                    m_axis_tdata_o,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gpad_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gpad_pkg::CNT_W-1:0]     cfg_data_i
);

  gpad_pkg::gpad_ctl_t        ctl;
  gpad_pkg::gpad_sts_t        sts;
  logic [gpad_pkg::MAP_W-1:0] last_levels;
  logic [gpad_pkg::MAP_W-1:0] hit;
  logic [gpad_pkg::MAP_W-1:0] levels, new_press, repeat_press;
  logic [gpad_pkg::CNT_W-1:0] hold_frames_q, repeat_period_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_frames_q   <= gpad_pkg::CNT_W'(15);
      repeat_period_q <= gpad_pkg::CNT_W'(6);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == gpad_pkg::CFG_HOLD_FRAMES) begin
        hold_frames_q <= cfg_data_i;
      end
      if (cfg_index_i == gpad_pkg::CFG_REPEAT_PERIOD) begin
        repeat_period_q <= cfg_data_i;
      end
    end
  end

  gpad_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // One lane per active button; unused bitmap positions never hit.
  for (genvar i = 0; i < gpad_pkg::MAP_W; i++) begin : g_lane
    if (i < gpad_pkg::LANES) begin : g_on
      gpad_lane u_lane (
        .clk_i           (clk_i),
        .rst_ni          (rst_ni),
        .ctl_i           (ctl),
        .cur_i           (s_axis_tdata_i[i]),
        .last_i          (last_levels[i]),
        .hold_frames_i   (hold_frames_q),
        .repeat_period_i (repeat_period_q),
        .hit_o           (hit[i])
      );
    end else begin : g_off
      assign hit[i] = 1'b0;
    end
  end

  gpad_merge u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .cur_i          (s_axis_tdata_i),
    .hit_i          (hit),
    .last_o         (last_levels),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .levels_o       (levels),
    .new_press_o    (new_press),
    .repeat_press_o (repeat_press)
  );

  assign m_axis_tdata_o = {repeat_press, new_press, levels};

  // A frame is never taken while lanes are being merged.
  a_load_not_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl.load |-> !ctl.merge)
    else $error("frame accepted during merge");

  // The block is busy in the cycle after a frame is accepted.
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("ready high right after an accepted frame");

  // A result appears only from a merge.
  a_valid_from_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid_o) |-> $past(ctl.merge))
    else $error("output valid without a merge");

  // Lane steps never overlap a frame load or a merge.
  a_step_not_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ctl.step |-> (!ctl.load && !ctl.merge))
    else $error("remainder step overlaps load or merge");

endmodule
